// ===== hdl/c8x_pkg.sv =====
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants for the instruction execute block
// Holds the payload structs, status codes and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none
package c8x_pkg;

   typedef struct packed {
      logic        cmd;
      logic [15:0] instruction;
      logic [15:0] keys_down;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic [11:0] next_pc;
      logic [11:0] index_value;
      logic        mem_write_valid;
      logic [11:0] mem_address;
      logic [7:0]  mem_data;
      logic        sound_on;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [1:0] STATUS_STACK       = 2'd2;

   localparam logic CMD_EXEC = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register file port request from the sequencer
   typedef struct packed {
      logic       we;
      logic [3:0] waddr;
      logic [7:0] wdata;
      logic [3:0] raddr_a;
      logic [3:0] raddr_b;
   } rf_req_type;

endpackage
`default_nettype wire

// ===== hdl/chip8_instruction_execute_top.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top: CHIP-8 instruction executor
// Executes one instruction or timer tick per transfer, emitting results.
// ----------------------------------------------------------------------------
//  channel | dir | payload            | handshake
//  req_    | in  | c8x_pkg::req_type  | req_valid / req_stall
//  rsp_    | out | c8x_pkg::rsp_type  | rsp_valid / rsp_stall
// An item goes through a register file and stack read, then execute, which
// waits while the output is blocked; ALU ops writing VX and VF add a flag
// write step. BCD gives three results and register store X+1, one per cycle
// while the output is free, registers read ahead. Synchronous reset clears
// control state but burst counters; next item is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module chip8_instruction_execute_top #(
   parameter int FONT_BASE     = 80,
   parameter int STACK_DEPTH   = 16,
   parameter int START_ADDRESS = 512
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire c8x_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output c8x_pkg::rsp_type      rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_BCD   = 4'b0100,
      S_STORE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   c8x_pkg::req_type item_ff, item_in;
   logic [11:0]      pc_ff, pc_in, idx_ff, idx_in;
   logic [4:0]       sp_ff, sp_in;
   logic [7:0]       dt_ff, dt_in, st_ff, st_in;
   logic [3:0]       k_ff, k_in;
   logic [1:0]       b_ff, b_in;
   logic [7:0]       bcd_ff [3];
   logic             bcd_ld;
   logic [7:0]       bcd_h, bcd_t, bcd_o;
   logic             ov_ff, ov_in;
   c8x_pkg::rsp_type out_ff, out_in;

   c8x_pkg::rf_req_type rf_req;
   logic [7:0]  vx, vy;
   logic        stk_we;
   logic [3:0]  stk_raddr;
   logic [11:0] stk_rdata;

   c8x_regfile u_rf (.clock, .reset, .rf_req, .rdata_a(vx), .rdata_b(vy));
   c8x_stack u_stk (.clock, .we(stk_we), .waddr(sp_ff[3:0]), .wdata(pc_ff + 12'd2),
                    .raddr(stk_raddr), .rdata(stk_rdata));

   logic out_free, accept;
   assign out_free  = !ov_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   logic [3:0]  x, y, n;
   logic [7:0]  nn;
   logic [11:0] nnn;
   assign x   = item_ff.instruction[11:8];
   assign y   = item_ff.instruction[7:4];
   assign n   = item_ff.instruction[3:0];
   assign nn  = item_ff.instruction[7:0];
   assign nnn = item_ff.instruction[11:0];

   // Binary-coded decimal of VX by compare and subtract
   always_comb begin
      logic [7:0] r;
      r = vx;
      bcd_h = 8'd0;
      if (r >= 8'd200) begin bcd_h = 8'd2; r = r - 8'd200; end
      else if (r >= 8'd100) begin bcd_h = 8'd1; r = r - 8'd100; end
      bcd_t = 8'd0;
      for (int i = 9; i >= 1; i--) begin
         if (bcd_t == 8'd0 && r >= 8'(i * 10)) begin
            bcd_t = 8'(i);
         end
      end
      bcd_o = r - 8'((bcd_t * 8'd10));
   end

   // Sequencer: decode, execute and drain the write bursts
   always_comb begin
      logic [11:0] pc2, t12;
      logic [12:0] s13;
      logic [8:0]  s9;
      logic [1:0]  status;
      logic        emit, key;
      state_in = state_ff;
      item_in  = item_ff;
      pc_in = pc_ff; idx_in = idx_ff; sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff;
      k_in = k_ff; b_in = b_ff; bcd_ld = 1'b0;
      ov_in  = ov_ff && rsp_stall;
      out_in = out_ff;
      rf_req = '0;
      stk_we = 1'b0;
      stk_raddr = sp_ff[3:0] - 4'd1;
      status = c8x_pkg::STATUS_OK;
      emit = 1'b0;
      pc2 = pc_ff + 12'd2;
      t12 = '0; s13 = '0; s9 = '0; key = 1'b0;
      // Port B reads V0 for the jump with offset, VY otherwise
      rf_req.raddr_a = req_data.instruction[11:8];
      rf_req.raddr_b = (req_data.instruction[15:12] == 4'hB) ? 4'd0
                                                             : req_data.instruction[7:4];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // Hold both read addresses while the output is blocked
            rf_req.raddr_a = x;
            rf_req.raddr_b = (item_ff.instruction[15:12] == 4'hB) ? 4'd0 : y;
            if (out_free) begin
               emit = 1'b1;
               state_in = S_IDLE;
               if (item_ff.cmd == c8x_pkg::CMD_TICK) begin
                  if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
                  if (st_ff != 8'd0) st_in = st_ff - 8'd1;
               end else begin
                  pc_in = pc2;
                  key = (vx < 8'd16) && item_ff.keys_down[vx[3:0]];
                  unique case (item_ff.instruction[15:12])
                     4'h0: begin
                        if (item_ff.instruction == 16'h00EE) begin
                           if (sp_ff == 5'd0 || sp_ff > 5'(STACK_DEPTH))
                              status = c8x_pkg::STATUS_STACK;
                           else begin
                              sp_in = sp_ff - 5'd1;
                              pc_in = stk_rdata;
                           end
                        end else status = c8x_pkg::STATUS_UNSUPPORTED;
                     end
                     4'h1: pc_in = nnn;
                     4'h2: begin
                        if (sp_ff >= 5'(STACK_DEPTH)) status = c8x_pkg::STATUS_STACK;
                        else begin
                           stk_we = 1'b1;
                           sp_in  = sp_ff + 5'd1;
                           pc_in  = nnn;
                        end
                     end
                     4'h3: if (vx == nn) pc_in = pc_ff + 12'd4;
                     4'h4: if (vx != nn) pc_in = pc_ff + 12'd4;
                     4'h5: if (n != 4'd0) status = c8x_pkg::STATUS_UNSUPPORTED;
                           else if (vx == vy) pc_in = pc_ff + 12'd4;
                     4'h6: begin rf_req.we = 1'b1; rf_req.waddr = x; rf_req.wdata = nn; end
                     4'h7: begin rf_req.we = 1'b1; rf_req.waddr = x; rf_req.wdata = vx + nn; end
                     4'h8: begin
                        // Flag result overrides VX when X is F
                        rf_req.we = 1'b1; rf_req.waddr = x;
                        unique case (n)
                           4'h0: rf_req.wdata = vy;
                           4'h1: rf_req.wdata = vx | vy;
                           4'h2: rf_req.wdata = vx & vy;
                           4'h3: rf_req.wdata = vx ^ vy;
                           4'h4: begin
                              s9 = {1'b0, vx} + {1'b0, vy};
                              rf_req.wdata = (x == 4'hF) ? {7'd0, s9[8]} : s9[7:0];
                           end
                           4'h5: rf_req.wdata = (x == 4'hF) ? {7'd0, vx >= vy} : vx - vy;
                           4'h6: rf_req.wdata = (x == 4'hF) ? {7'd0, vx[0]} : {1'b0, vx[7:1]};
                           4'h7: rf_req.wdata = (x == 4'hF) ? {7'd0, vy >= vx} : vy - vx;
                           4'hE: rf_req.wdata = (x == 4'hF) ? {7'd0, vx[7]} : {vx[6:0], 1'b0};
                           default: begin
                              rf_req.we = 1'b0;
                              status = c8x_pkg::STATUS_UNSUPPORTED;
                           end
                        endcase
                        // Second write for the flag goes through the burst path
                        if (rf_req.we && x != 4'hF && (n == 4'h4 || n == 4'h5 ||
                            n == 4'h6 || n == 4'h7 || n == 4'hE)) begin
                           emit = 1'b0;
                           state_in = S_BCD;
                           b_in = 2'd3;
                           bcd_ld = 1'b1;
                        end
                     end
                     4'h9: if (n != 4'd0) status = c8x_pkg::STATUS_UNSUPPORTED;
                           else if (vx != vy) pc_in = pc_ff + 12'd4;
                     4'hA: idx_in = nnn;
                     // Port B carries V0 here
                     4'hB: pc_in = nnn + {4'd0, vy};
                     4'hC: begin
                        rf_req.we = 1'b1; rf_req.waddr = x;
                        rf_req.wdata = item_ff.random_byte & nn;
                     end
                     4'hD: status = c8x_pkg::STATUS_UNSUPPORTED;
                     4'hE: begin
                        if (nn == 8'h9E) begin if (key) pc_in = pc_ff + 12'd4; end
                        else if (nn == 8'hA1) begin if (!key) pc_in = pc_ff + 12'd4; end
                        else status = c8x_pkg::STATUS_UNSUPPORTED;
                     end
                     default: begin
                        unique case (nn)
                           8'h07: begin rf_req.we = 1'b1; rf_req.waddr = x; rf_req.wdata = dt_ff; end
                           8'h15: dt_in = vx;
                           8'h18: st_in = vx;
                           8'h1E: begin
                              s13 = {1'b0, idx_ff} + {5'd0, vx};
                              idx_in = s13[11:0];
                              rf_req.we = 1'b1; rf_req.waddr = 4'hF;
                              rf_req.wdata = {7'd0, s13[12]};
                           end
                           8'h29: begin
                              t12 = 12'(FONT_BASE) + {4'd0, vx} + {2'd0, vx, 2'd0};
                              idx_in = t12;
                           end
                           8'h33: begin
                              emit = 1'b0; state_in = S_BCD; b_in = 2'd0; bcd_ld = 1'b1;
                           end
                           8'h55: begin
                              emit = 1'b0; state_in = S_STORE; k_in = 4'd0;
                              rf_req.raddr_a = 4'd0;
                           end
                           default: status = c8x_pkg::STATUS_UNSUPPORTED;
                        endcase
                     end
                  endcase
               end
               if (emit) begin
                  ov_in = 1'b1;
                  out_in = '0;
                  out_in.next_pc = pc_in;
                  out_in.index_value = idx_in;
                  out_in.sound_on = (st_in != 8'd0);
                  out_in.status = status;
                  out_in.last = 1'b1;
               end
            end
         end
         S_BCD: begin
            rf_req.raddr_a = x;
            if (b_ff == 2'd3) begin
               // Deferred flag write for the ALU ops, together with the single result
               if (out_free) begin
                  rf_req.we = 1'b1; rf_req.waddr = 4'hF;
                  rf_req.wdata = bcd_ff[0];
                  ov_in = 1'b1; out_in = '0;
                  out_in.next_pc = pc_ff; out_in.index_value = idx_ff;
                  out_in.sound_on = (st_ff != 8'd0); out_in.last = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (out_free) begin
               ov_in = 1'b1; out_in = '0;
               out_in.next_pc = pc_ff; out_in.index_value = idx_ff;
               out_in.sound_on = (st_ff != 8'd0);
               out_in.mem_write_valid = 1'b1;
               out_in.mem_address = idx_ff + {10'd0, b_ff};
               out_in.mem_data = bcd_ff[b_ff];
               out_in.last = (b_ff == 2'd2);
               b_in = b_ff + 2'd1;
               if (b_ff == 2'd2) state_in = S_IDLE;
            end
         end
         S_STORE: begin
            rf_req.raddr_a = k_ff;
            if (out_free) begin
               ov_in = 1'b1; out_in = '0;
               out_in.next_pc = pc_ff; out_in.index_value = idx_ff;
               out_in.sound_on = (st_ff != 8'd0);
               out_in.mem_write_valid = 1'b1;
               out_in.mem_address = idx_ff + {8'd0, k_ff};
               out_in.mem_data = vx;
               out_in.last = (k_ff == x);
               k_in = k_ff + 4'd1;
               rf_req.raddr_a = k_ff + 4'd1;
               if (k_ff == x) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Flag values for the deferred ALU write
   logic [7:0] flag_v;
   always_comb begin
      unique case (n)
         4'h4: flag_v = {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
         4'h5: flag_v = {7'd0, vx >= vy};
         4'h6: flag_v = {7'd0, vx[0]};
         4'h7: flag_v = {7'd0, vy >= vx};
         default: flag_v = {7'd0, vx[7]};
      endcase
   end

   // Hold registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
      k_ff    <= k_in;
      b_ff    <= b_in;
      if (bcd_ld) begin
         if (b_in == 2'd3) bcd_ff[0] <= flag_v;
         else begin
            bcd_ff[0] <= bcd_h; bcd_ff[1] <= bcd_t; bcd_ff[2] <= bcd_o;
         end
      end
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= 12'(START_ADDRESS);
         idx_ff <= '0; sp_ff <= '0; dt_ff <= '0; st_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in; idx_ff <= idx_in; sp_ff <= sp_in;
         dt_ff <= dt_in; st_ff <= st_in; ov_ff <= ov_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/c8x_regfile.sv =====
// ----------------------------------------------------------------------------
// c8x_regfile: data register memory V0..VF
// Two synchronous read ports, one write port, valid bits model the reset.
// ----------------------------------------------------------------------------
`default_nettype none
module c8x_regfile (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire c8x_pkg::rf_req_type rf_req,
   output logic [7:0]               rdata_a,
   output logic [7:0]               rdata_b
);
   logic [7:0]  mem [16];
   logic [15:0] valid_ff;
   logic [7:0]  ra_ff, rb_ff;
   logic        va_ff, vb_ff;

   // Write port and valid bits
   always_ff @(posedge clock) begin
      if (rf_req.we) mem[rf_req.waddr] <= rf_req.wdata;
      if (reset) valid_ff <= '0;
      else if (rf_req.we) valid_ff[rf_req.waddr] <= 1'b1;
   end

   // Registered reads
   always_ff @(posedge clock) begin
      ra_ff <= mem[rf_req.raddr_a];
      rb_ff <= mem[rf_req.raddr_b];
      va_ff <= valid_ff[rf_req.raddr_a];
      vb_ff <= valid_ff[rf_req.raddr_b];
   end

   assign rdata_a = va_ff ? ra_ff : 8'd0;
   assign rdata_b = vb_ff ? rb_ff : 8'd0;
endmodule
`default_nettype wire

// ===== hdl/c8x_stack.sv =====
// ----------------------------------------------------------------------------
// c8x_stack: return address memory
// One write and one synchronous read address per cycle; no reset.
// ----------------------------------------------------------------------------
`default_nettype none
module c8x_stack (
   input  wire logic        clock,
   input  wire logic        we,
   input  wire logic [3:0]  waddr,
   input  wire logic [11:0] wdata,
   input  wire logic [3:0]  raddr,
   output logic [11:0]      rdata
);
   logic [11:0] mem [16];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the instruction execute block
// Drives a directed table then random instruction streams, predicts each
// result in the bench and compares every response field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

   localparam int FONT_BASE     = 80;
   localparam int STACK_DEPTH   = 16;
   localparam int START_ADDRESS = 512;
   localparam int WATCHDOG      = 20000;
   localparam int NUM_RANDOM    = 135;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   c8x_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   c8x_pkg::rsp_type rsp_data;

   chip8_instruction_execute_top #(
      .FONT_BASE(FONT_BASE), .STACK_DEPTH(STACK_DEPTH), .START_ADDRESS(START_ADDRESS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow machine state
   logic [7:0]  vreg [16];
   logic [11:0] idx_reg;
   logic [11:0] pc_reg;
   logic [11:0] call_stack [16];
   logic [4:0]  sp_reg;
   logic [7:0]  delay_tmr;
   logic [7:0]  sound_tmr;

   c8x_pkg::rsp_type pending_rsp [$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      quiet_cycles = 0;

   function automatic c8x_pkg::rsp_type make_rsp(logic wr, logic [11:0] addr,
                                                 logic [7:0] data, logic [1:0] st,
                                                 logic lst);
      c8x_pkg::rsp_type r;
      r.next_pc         = pc_reg;
      r.index_value     = idx_reg;
      r.mem_write_valid = wr;
      r.mem_address     = wr ? addr : 12'd0;
      r.mem_data        = wr ? data : 8'd0;
      r.sound_on        = (sound_tmr != 0);
      r.status          = st;
      r.last            = lst;
      return r;
   endfunction

   // Advance the shadow machine by one item and queue its results
   task automatic execute_predict(input c8x_pkg::req_type it);
      logic [15:0] op;
      logic [3:0]  hi, x, y, n;
      logic [7:0]  nn, vx, vy;
      logic [11:0] nnn;
      logic [1:0]  st;
      logic [8:0]  sum9;
      logic [12:0] sum13;
      logic        pressed;
      op  = it.instruction;
      hi  = op[15:12]; x = op[11:8]; y = op[7:4]; n = op[3:0];
      nn  = op[7:0];   nnn = op[11:0];
      vx  = vreg[x];   vy = vreg[y];
      st  = c8x_pkg::STATUS_OK;
      pressed = (vx < 16) && it.keys_down[vx[3:0]];
      if (it.cmd == c8x_pkg::CMD_TICK) begin
         if (delay_tmr != 0) delay_tmr--;
         if (sound_tmr != 0) sound_tmr--;
         pending_rsp.push_back(make_rsp(1'b0, '0, '0, c8x_pkg::STATUS_OK, 1'b1));
         return;
      end
      pc_reg = pc_reg + 12'd2;
      case (hi)
         4'h0: begin
            if (op == 16'h00EE) begin
               if (sp_reg == 0 || sp_reg > STACK_DEPTH) st = c8x_pkg::STATUS_STACK;
               else begin
                  sp_reg--;
                  pc_reg = call_stack[sp_reg[3:0]];
               end
            end else st = c8x_pkg::STATUS_UNSUPPORTED;
         end
         4'h1: pc_reg = nnn;
         4'h2: begin
            if (sp_reg >= STACK_DEPTH) st = c8x_pkg::STATUS_STACK;
            else begin
               call_stack[sp_reg[3:0]] = pc_reg;
               sp_reg++;
               pc_reg = nnn;
            end
         end
         4'h3: if (vx == nn) pc_reg += 12'd2;
         4'h4: if (vx != nn) pc_reg += 12'd2;
         4'h5: if (n != 0) st = c8x_pkg::STATUS_UNSUPPORTED;
               else if (vx == vy) pc_reg += 12'd2;
         4'h6: vreg[x] = nn;
         4'h7: vreg[x] = vx + nn;
         4'h8: begin
            case (n)
               4'h0: vreg[x] = vy;
               4'h1: vreg[x] = vx | vy;
               4'h2: vreg[x] = vx & vy;
               4'h3: vreg[x] = vx ^ vy;
               4'h4: begin
                  sum9 = {1'b0, vx} + {1'b0, vy};
                  vreg[x] = sum9[7:0];
                  vreg[15] = {7'd0, sum9[8]};
               end
               4'h5: begin vreg[x] = vx - vy; vreg[15] = {7'd0, vx >= vy}; end
               4'h6: begin vreg[x] = vx >> 1; vreg[15] = {7'd0, vx[0]}; end
               4'h7: begin vreg[x] = vy - vx; vreg[15] = {7'd0, vy >= vx}; end
               4'hE: begin vreg[x] = vx << 1; vreg[15] = {7'd0, vx[7]}; end
               default: st = c8x_pkg::STATUS_UNSUPPORTED;
            endcase
         end
         4'h9: if (n != 0) st = c8x_pkg::STATUS_UNSUPPORTED;
               else if (vx != vy) pc_reg += 12'd2;
         4'hA: idx_reg = nnn;
         4'hB: pc_reg = nnn + {4'd0, vreg[0]};
         4'hC: vreg[x] = it.random_byte & nn;
         4'hD: st = c8x_pkg::STATUS_UNSUPPORTED;
         4'hE: begin
            if (nn == 8'h9E) begin
               if (pressed) pc_reg += 12'd2;
            end else if (nn == 8'hA1) begin
               if (!pressed) pc_reg += 12'd2;
            end else st = c8x_pkg::STATUS_UNSUPPORTED;
         end
         default: begin
            case (nn)
               8'h07: vreg[x] = delay_tmr;
               8'h15: delay_tmr = vx;
               8'h18: sound_tmr = vx;
               8'h1E: begin
                  sum13 = {1'b0, idx_reg} + {5'd0, vx};
                  idx_reg = sum13[11:0];
                  vreg[15] = {7'd0, sum13[12]};
               end
               8'h29: idx_reg = 12'(FONT_BASE + vx * 5);
               8'h33: begin
                  pending_rsp.push_back(make_rsp(1'b1, idx_reg, 8'(vx / 100),
                                                 c8x_pkg::STATUS_OK, 1'b0));
                  pending_rsp.push_back(make_rsp(1'b1, idx_reg + 12'd1, 8'((vx / 10) % 10),
                                                 c8x_pkg::STATUS_OK, 1'b0));
                  pending_rsp.push_back(make_rsp(1'b1, idx_reg + 12'd2, 8'(vx % 10),
                                                 c8x_pkg::STATUS_OK, 1'b1));
                  return;
               end
               8'h55: begin
                  for (int k = 0; k <= x; k++)
                     pending_rsp.push_back(make_rsp(1'b1, 12'(idx_reg + k), vreg[k],
                                                    c8x_pkg::STATUS_OK, k == x));
                  return;
               end
               default: st = c8x_pkg::STATUS_UNSUPPORTED;
            endcase
         end
      endcase
      pending_rsp.push_back(make_rsp(1'b0, '0, '0, st, 1'b1));
   endtask

   // Hand one item over and hold it until the transfer
   task automatic send_item(input c8x_pkg::req_type it);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      execute_predict(it);
   endtask

   function automatic c8x_pkg::req_type exec_item(logic [15:0] op, logic [15:0] keys,
                                                  logic [7:0] rnd);
      c8x_pkg::req_type r;
      r.cmd = c8x_pkg::CMD_EXEC; r.instruction = op; r.keys_down = keys; r.random_byte = rnd;
      return r;
   endfunction

   // Pick an instruction, mostly well formed
   function automatic logic [15:0] pick_op();
      logic [15:0] op;
      logic [3:0]  hi;
      logic [7:0]  fx_ops [9] = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h0A};
      logic [3:0]  alu_ops [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE, 4'h9};
      op = 16'($urandom_range(16'hFFFF, 0));
      hi = op[15:12];
      case ($urandom_range(9, 0))
         0: op = 16'h00EE;
         1: op = {8'hF0 | op[11:8], fx_ops[$urandom_range(8, 0)]};
         2: op = {4'h8, op[11:4], alu_ops[$urandom_range(9, 0)]};
         3: op = {4'hE, op[11:8], ($urandom_range(1, 0) ? 8'h9E : 8'hA1)};
         4: op = {4'h6, op[11:0]};
         5: op = {hi == 4'h5 ? 4'h9 : 4'h5, op[11:4], 4'h0};
         default: ;
      endcase
      return op;
   endfunction

   // Receiver: stall at random and check every transfer
   always @(posedge clock) begin
      c8x_pkg::rsp_type want;
      if (!reset) begin
         rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99, 0) < recv_idle_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.next_pc != want.next_pc) begin
                  $error("next_pc expected %h got %h", want.next_pc, rsp_data.next_pc);
                  fail_count++;
               end
               if (rsp_data.index_value != want.index_value) begin
                  $error("index_value expected %h got %h", want.index_value,
                         rsp_data.index_value);
                  fail_count++;
               end
               if (rsp_data.mem_write_valid != want.mem_write_valid) begin
                  $error("mem_write_valid expected %b got %b", want.mem_write_valid,
                         rsp_data.mem_write_valid);
                  fail_count++;
               end
               if (rsp_data.mem_address != want.mem_address) begin
                  $error("mem_address expected %h got %h", want.mem_address,
                         rsp_data.mem_address);
                  fail_count++;
               end
               if (rsp_data.mem_data != want.mem_data) begin
                  $error("mem_data expected %h got %h", want.mem_data, rsp_data.mem_data);
                  fail_count++;
               end
               if (rsp_data.sound_on != want.sound_on) begin
                  $error("sound_on expected %b got %b", want.sound_on, rsp_data.sound_on);
                  fail_count++;
               end
               if (rsp_data.status != want.status) begin
                  $error("status expected %d got %d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.last != want.last) begin
                  $error("last expected %b got %b", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on stalled progress
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   typedef struct {
      c8x_pkg::req_type item;
      logic             check_fixed;
      logic [11:0]      pc_fixed;
      logic [1:0]       status_fixed;
   } directed_row;

   directed_row directed [$];

   initial begin
      c8x_pkg::req_type it;
      int      drain;
      // Directed rows: fixed values typed only where obvious
      directed.push_back('{exec_item(16'h00E0, 16'h0000, 8'h00), 1, 12'h202,
                           c8x_pkg::STATUS_UNSUPPORTED});
      directed.push_back('{exec_item(16'h00EE, 16'hFFFF, 8'hFF), 1, 12'h204,
                           c8x_pkg::STATUS_STACK});
      directed.push_back('{exec_item(16'h6FFF, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h60FF, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h8F04, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h8015, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h806E, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h8F06, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h8017, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hBFFF, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hAFFF, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h6280, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hF21E, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hF029, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hF133, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hFF55, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hC3FF, 16'hFFFF, 8'hA5), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hE29E, 16'h8000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hE2A1, 16'hFFFF, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hF018, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hF015, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{'{c8x_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF}, 0, '0,
                           c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'hF407, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h2ABC, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});
      directed.push_back('{exec_item(16'h00EE, 16'h0000, 8'h00), 0, '0, c8x_pkg::STATUS_OK});

      foreach (vreg[i]) vreg[i] = 8'd0;
      foreach (call_stack[i]) call_stack[i] = 12'd0;
      idx_reg = 12'd0; pc_reg = 12'(START_ADDRESS); sp_reg = 5'd0;
      delay_tmr = 8'd0; sound_tmr = 8'd0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_item(directed[i].item);
         if (directed[i].check_fixed) begin
            pending_rsp[pending_rsp.size() - 1].next_pc = directed[i].pc_fixed;
            pending_rsp[pending_rsp.size() - 1].status  = directed[i].status_fixed;
         end
      end

      // Random phases: receiver-heavy stalling, sender-heavy idling, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 75 : 0;
         recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 21 : 0;
         for (int k = 0; k < NUM_RANDOM / 3; k++) begin
            it.cmd         = ($urandom_range(9, 0) == 0) ? c8x_pkg::CMD_TICK
                                                         : c8x_pkg::CMD_EXEC;
            it.instruction = pick_op();
            it.keys_down   = 16'($urandom_range(16'hFFFF, 0));
            it.random_byte = 8'($urandom_range(8'hFF, 0));
            send_item(it);
         end
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_rsp.size() != 0 && drain < WATCHDOG) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
